// ----- src/rmme_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmme_pkg
// Shared types, action codes and status codes of the rotor mixing engine.
// ----------------------------------------------------------------------------
package rmme_pkg;

    localparam int DEF_MAX_MOTORS   = 8;
    localparam int DEF_MAX_CHANNELS = 6;

    localparam logic [2:0] ACT_WRITE = 3'd0;
    localparam logic [2:0] ACT_READY = 3'd1;
    localparam logic [2:0] ACT_CLEAR = 3'd2;
    localparam logic [2:0] ACT_ADD   = 3'd3;
    localparam logic [2:0] ACT_CHECK = 3'd4;
    localparam logic [2:0] ACT_READ  = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOT_RDY = 2'd1;
    localparam logic [1:0] ST_BAD_CH  = 2'd2;

    localparam logic [0:0] CFG_ROTORS   = 1'b0;
    localparam logic [0:0] CFG_CHANNELS = 1'b1;

    localparam logic signed [23:0] LVL_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] LVL_MIN = 24'sh800000;

    // Classified command handed from front to back.
    typedef struct packed {
        logic [2:0]         action;
        logic [1:0]         status;   // non-ok: back only reports it
        logic [2:0]         channel;
        logic [2:0]         rotor;    // table column for a write
        logic [3:0]         nrot;     // rotors in use, 1..8
        logic signed [15:0] value;
    } t_cmd;

endpackage

// ----- src/rmme_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmme_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rmme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/rmme_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmme_front
// Accepts commands, checks ready and channel, keeps the ready mark, and
// queues every command for the back end.
// ----------------------------------------------------------------------------
module rmme_front
    import rmme_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [2:0]    i_action,
    input  logic [2:0]    i_channel,
    input  logic [2:0]    i_rotor,
    input  logic [15:0]   i_value,
    input  logic [3:0]    i_nrot,
    input  logic [3:0]    i_nch,
    input  logic          i_q_full,
    output logic          o_busy,
    output logic          o_push,
    output t_cmd          o_cmd
);
    logic r_ready;
    logic accept;
    logic ch_bad;
    logic need_rdy;

    assign o_busy = i_q_full;
    assign accept = i_start && !i_q_full;
    assign ch_bad = {1'b0, i_channel} >= i_nch;
    assign need_rdy = (i_action == ACT_ADD) || (i_action == ACT_CHECK);

    always_comb begin
        o_cmd.action  = i_action;
        o_cmd.channel = i_channel;
        o_cmd.rotor   = i_rotor;
        o_cmd.nrot    = i_nrot;
        o_cmd.value   = i_value;
        o_cmd.status  = ST_OK;
        if (i_action == ACT_WRITE) begin
            o_cmd.status = ch_bad ? ST_BAD_CH : ST_OK;
        end else if (need_rdy) begin
            if (!r_ready) begin
                o_cmd.status = ST_NOT_RDY;
            end else if (ch_bad) begin
                o_cmd.status = ST_BAD_CH;
            end
        end
    end

    assign o_push = accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
        end else if (accept && i_action == ACT_READY) begin
            r_ready <= 1'b1;
        end
    end
endmodule

// ----- src/rmme_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmme_queue
// Two-entry command queue between the front and the back end.
// ----------------------------------------------------------------------------
module rmme_queue
    import rmme_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);
    t_cmd       r_mem [2];
    logic       r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;

    always_comb begin
        n_wp  = r_wp ^ i_push;
        n_rp  = r_rp ^ i_pop;
        n_cnt = r_cnt + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_cmd   = r_mem[r_rp];

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("queue underflow");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
`endif
endmodule

// ----- src/rmme_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmme_back
// Executes queued commands in order: table writes, and rotor walks for add,
// check and read, with a shared bit-serial divider for the bound candidates.
// ----------------------------------------------------------------------------
module rmme_back
    import rmme_pkg::*;
#(
    parameter int MAX_MOTORS   = DEF_MAX_MOTORS,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    localparam int AW = $clog2(MAX_MOTORS * MAX_CHANNELS),
    localparam int MW = (MAX_MOTORS > 1) ? $clog2(MAX_MOTORS) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_cmd               i_cmd,
    output logic               o_pop,
    output logic               o_we,
    output logic [AW-1:0]      o_waddr,
    output logic [15:0]        o_wdata,
    output logic [AW-1:0]      o_raddr,
    input  logic [15:0]        i_rdata,
    output logic               o_done,
    output logic [1:0]         o_status,
    output logic signed [23:0] o_lower_bound,
    output logic signed [23:0] o_upper_bound,
    output logic [2:0]         o_motor_index,
    output logic signed [23:0] o_motor_level,
    output logic               o_last
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FET  = 3'd1;
    localparam logic [2:0] S_USE  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_NEXT = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;
    localparam int QW = 40;

    logic [2:0]         r_st;
    t_cmd               r_cmd;
    logic [MW-1:0]      r_i;
    logic signed [23:0] r_lvl [MAX_MOTORS];
    logic signed [47:0] r_lo, r_hi;
    logic signed [31:0] r_prod;
    logic               r_pv;
    // divider
    logic [QW-1:0]      r_num;
    logic [15:0]        r_den;
    logic [QW-1:0]      r_quo;
    logic [16:0]        r_rem;
    logic [5:0]         r_bit;
    logic               r_neg;
    logic               r_second;
    logic signed [15:0] r_c;
    logic signed [QW:0] r_top;

    logic signed [23:0] m_cur;
    logic [MW-1:0]      last_i;
    logic signed [24:0] sum;
    logic signed [23:0] d_add;
    logic [16:0]        rem_sh;
    logic signed [QW:0] q_s;
    logic signed [QW:0] a_num, b_num;
    logic signed [QW:0] top_v, bot_v;

    assign m_cur  = r_lvl[r_i];
    assign last_i = MW'(r_cmd.nrot - 4'd1);
    assign o_raddr = AW'(r_cmd.channel * MAX_MOTORS) + AW'(r_i);
    assign o_pop  = (r_st == S_IDLE) && i_valid;
    // write the table when the write reaches the back, behind earlier walks
    assign o_we    = o_pop && (i_cmd.action == ACT_WRITE) && (i_cmd.status == ST_OK) &&
                     ({2'b0, i_cmd.rotor} < 5'(MAX_MOTORS));
    assign o_waddr = AW'(i_cmd.channel * MAX_MOTORS) + AW'(i_cmd.rotor);
    assign o_wdata = i_cmd.value;
    // floor((p + 2^13) / 2^14) via arithmetic shift
    assign d_add = 24'(r_prod + 32'sd8192 >>> 14);
    assign sum   = 25'(m_cur) + 25'(d_add);
    assign rem_sh = {r_rem[15:0], r_num[QW-1]};
    assign q_s   = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign a_num = ((QW+1)'(32'sd16384) - (QW+1)'(m_cur)) <<< 14;
    assign b_num = -((QW+1)'(m_cur) <<< 14);
    assign top_v = (r_c < 0) ? q_s : r_top;
    assign bot_v = (r_c < 0) ? r_top : q_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            o_done <= 1'b0;
            for (int k = 0; k < MAX_MOTORS; k++) r_lvl[k] <= '0;
        end else begin
            o_done <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd <= i_cmd;
                        r_i   <= '0;
                        r_lo  <= 48'(LVL_MIN);
                        r_hi  <= 48'(LVL_MAX);
                        r_pv  <= 1'b0;
                        if (i_cmd.status != ST_OK) begin
                            r_st <= S_OUT;
                        end else if (i_cmd.action == ACT_CLEAR) begin
                            for (int k = 0; k < MAX_MOTORS; k++) r_lvl[k] <= '0;
                            r_st <= S_OUT;
                        end else if (i_cmd.action == ACT_ADD ||
                                     i_cmd.action == ACT_CHECK) begin
                            r_st <= S_FET;
                        end else if (i_cmd.action == ACT_READ) begin
                            r_st <= S_OUT;
                        end else begin
                            r_st <= S_OUT;
                        end
                    end
                end
                S_FET: r_st <= S_USE;   // wait for table read
                S_USE: begin
                    r_c <= $signed(i_rdata);
                    if (r_cmd.action == ACT_ADD) begin
                        if (!r_pv) begin
                            r_prod <= 32'(r_cmd.value) * 32'($signed(i_rdata));
                            r_pv   <= 1'b1;
                        end else begin
                            r_lvl[r_i] <= (sum > 25'(LVL_MAX)) ? LVL_MAX :
                                          (sum < 25'(LVL_MIN)) ? LVL_MIN :
                                          24'(sum);
                            r_pv <= 1'b0;
                            r_st <= S_NEXT;
                        end
                    end else if (i_rdata == 16'd0) begin
                        r_st <= S_NEXT;
                    end else begin
                        r_second <= 1'b0;
                        r_num <= QW'(a_num < 0 ? -a_num : a_num);
                        r_neg <= (a_num < 0) ^ i_rdata[15];
                        r_den <= i_rdata[15] ? 16'(-$signed(i_rdata)) : i_rdata;
                        r_quo <= '0;
                        r_rem <= '0;
                        r_bit <= 6'(QW);
                        r_st  <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_bit != 6'd0) begin
                        r_num <= {r_num[QW-2:0], 1'b0};
                        if (rem_sh >= {1'b0, r_den}) begin
                            r_rem <= rem_sh - {1'b0, r_den};
                            r_quo <= {r_quo[QW-2:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh;
                            r_quo <= {r_quo[QW-2:0], 1'b0};
                        end
                        r_bit <= r_bit - 6'd1;
                    end else if (!r_second) begin
                        r_top    <= q_s;
                        r_second <= 1'b1;
                        r_num <= QW'(b_num < 0 ? -b_num : b_num);
                        r_neg <= (b_num < 0) ^ r_c[15];
                        r_quo <= '0;
                        r_rem <= '0;
                        r_bit <= 6'(QW);
                    end else begin
                        if (48'(top_v) < r_hi) r_hi <= 48'(top_v);
                        if (48'(bot_v) > r_lo) r_lo <= 48'(bot_v);
                        r_st <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_i == last_i) begin
                        r_st <= S_OUT;
                    end else begin
                        r_i  <= r_i + MW'(1);
                        r_st <= S_FET;
                    end
                end
                S_OUT: begin
                    o_done <= 1'b1;
                    if (r_cmd.action == ACT_READ && r_cmd.status == ST_OK &&
                        r_i != last_i) begin
                        r_i <= r_i + MW'(1);
                    end else begin
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // result fields registered alongside o_done
    always_ff @(posedge i_clk) begin
        o_status      <= r_cmd.status;
        o_lower_bound <= '0;
        o_upper_bound <= '0;
        o_motor_index <= '0;
        o_motor_level <= '0;
        o_last        <= 1'b1;
        if (r_cmd.status == ST_OK && r_cmd.action == ACT_CHECK) begin
            o_lower_bound <= (r_lo > 48'(LVL_MAX)) ? LVL_MAX :
                             (r_lo < 48'(LVL_MIN)) ? LVL_MIN : 24'(r_lo);
            o_upper_bound <= (r_hi > 48'(LVL_MAX)) ? LVL_MAX :
                             (r_hi < 48'(LVL_MIN)) ? LVL_MIN : 24'(r_hi);
        end
        if (r_cmd.action == ACT_READ) begin
            o_motor_index <= 3'(r_i);
            o_motor_level <= m_cur;
            o_last        <= r_i == last_i;
        end
    end

`ifndef SYNTHESIS
    a_idle_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_st == S_IDLE) else $error("pop while working");
    a_done_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_st) == S_OUT) else $error("stray done");
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_DIV |-> r_bit <= 6'(QW)) else $error("divider overrun");
`endif
endmodule

// ----- src/rotor_mixing_matrix_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotor_mixing_matrix_engine
// Motor mixing matrix: coefficient table, motor accumulators, bound check.
// ----------------------------------------------------------------------------
// Results appear on o_done for one cycle and cannot be held off. The back end
// takes a command from the queue when it is idle. Write, mark ready, clear and
// unknown actions give a single beat; add walks the rotors in use, fetching
// each coefficient and then adding its scaled product; read gives one beat per
// cycle per rotor. A saturation check skips the divider on a zero coefficient
// and runs a 40-step bit-serial divider twice on a nonzero one. A two-entry
// command queue sits between the front and the back end; busy is high while
// it is full.
module rotor_mixing_matrix_engine
    import rmme_pkg::*;
#(
    parameter int MAX_MOTORS   = DEF_MAX_MOTORS,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_index,
    input  logic [3:0]         i_cfg_data,
    input  logic [2:0]         i_action,
    input  logic [2:0]         i_channel,
    input  logic [2:0]         i_rotor,
    input  logic signed [15:0] i_value,
    output logic               o_done,
    output logic [1:0]         o_status,
    output logic signed [23:0] o_lower_bound,
    output logic signed [23:0] o_upper_bound,
    output logic [2:0]         o_motor_index,
    output logic signed [23:0] o_motor_level,
    output logic               o_last
);
    localparam int DEPTH = MAX_MOTORS * MAX_CHANNELS;
    localparam int AW    = $clog2(DEPTH);

    logic [3:0] r_rotors, r_chans;
    logic [3:0] nrot, nch;
    logic push, pop, full, qv, we;
    t_cmd cmd_in, cmd_out;
    logic [AW-1:0] waddr, raddr;
    logic [15:0] wdata, rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotors <= 4'd4;
            r_chans  <= 4'd4;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_ROTORS) r_rotors <= i_cfg_data;
            else r_chans <= {1'b0, i_cfg_data[2:0]};
        end
    end

    assign nrot = (r_rotors == 4'd0) ? 4'd1 :
                  ({1'b0, r_rotors} > 5'(MAX_MOTORS)) ? 4'(MAX_MOTORS) : r_rotors;
    assign nch  = (r_chans == 4'd0) ? 4'd1 :
                  ({1'b0, r_chans} > 5'(MAX_CHANNELS)) ? 4'(MAX_CHANNELS) : r_chans;

    rmme_front u_front (
        .i_clk, .i_rst_n, .i_start(start), .i_action, .i_channel, .i_rotor,
        .i_value, .i_nrot(nrot), .i_nch(nch), .i_q_full(full), .o_busy(busy),
        .o_push(push), .o_cmd(cmd_in)
    );

    rmme_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_cmd(cmd_in), .i_pop(pop),
        .o_full(full), .o_valid(qv), .o_cmd(cmd_out)
    );

    rmme_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram (
        .i_clk, .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    rmme_back #(.MAX_MOTORS(MAX_MOTORS), .MAX_CHANNELS(MAX_CHANNELS)) u_back (
        .i_clk, .i_rst_n, .i_valid(qv), .i_cmd(cmd_out), .o_pop(pop),
        .o_we(we), .o_waddr(waddr), .o_wdata(wdata),
        .o_raddr(raddr), .i_rdata(rdata), .o_done, .o_status, .o_lower_bound,
        .o_upper_bound, .o_motor_index, .o_motor_level, .o_last
    );
endmodule
